[src/tlfg_pkg.sv]
package tlfg_pkg;

  // Fixed point format of coordinates, values and gradient
  localparam int FRAC_BITS = 16;

  localparam int XW  = 32;            // port word
  localparam int DW  = XW + 1;        // corner / value differences
  localparam int PW  = 2 * DW;        // difference products
  localparam int NW  = PW + 1;        // normal n and weighted edge w
  localparam int LO  = 32;            // low slice of a wide multiply
  localparam int HIW = NW - LO;       // signed high slice
  localparam int MW  = 2 * NW;        // wide product
  localparam int CW  = MW + 1;        // component of n x w
  localparam int SW  = MW;            // |n|^2, unsigned
  localparam int QW  = 32;            // quotient bits kept
  localparam int RW  = SW + 1 + QW;   // divider remainder

  // Cycles from the accepting edge to the edge that takes the result
  localparam int LAT = 40;

  typedef logic signed [XW-1:0] xw_t;
  typedef logic signed [NW-1:0] nw_t;
  typedef logic signed [MW-1:0] mw_t;
  typedef logic signed [CW-1:0] cw_t;
  typedef logic        [SW-1:0] sw_t;

  // Control that travels with each word
  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

[src/tlfg_front.sv]
module tlfg_front
  import tlfg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  xw_t  p1_i [3],
  input  xw_t  p2_i [3],
  input  xw_t  p3_i [3],
  input  xw_t  v1_i,
  input  xw_t  v2_i,
  input  xw_t  v3_i,
  output nw_t  n_o [3],
  output nw_t  w_o [3],
  output ctl_t ctl_o
);

  logic signed [DW-1:0] d2_q [3];
  logic signed [DW-1:0] d3_q [3];
  logic signed [DW-1:0] g2_q, g3_q;
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [PW-1:0] wa_q [3];
  logic signed [PW-1:0] wb_q [3];
  nw_t                  n_q [3];
  nw_t                  w_q [3];
  logic [2:0]           vld_q;
  logic                 degen_q;
  logic [2:0]           nzero;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Edge and value differences
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d2_q[k] <= DW'(p2_i[k]) - DW'(p1_i[k]);
      d3_q[k] <= DW'(p3_i[k]) - DW'(p1_i[k]);
    end
    g2_q <= DW'(v2_i) - DW'(v1_i);
    g3_q <= DW'(v3_i) - DW'(v1_i);
  end

  // Products for the normal and the weighted edge
  for (genvar k = 0; k < 3; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      pa_q[k] <= d2_q[(k+1)%3] * d3_q[(k+2)%3];
      pb_q[k] <= d2_q[(k+2)%3] * d3_q[(k+1)%3];
      wa_q[k] <= g3_q * d2_q[k];
      wb_q[k] <= g2_q * d3_q[k];
    end
    assign nzero[k] = (pa_q[k] == pb_q[k]);
  end

  // n = d2 x d3, w = g3*d2 - g2*d3
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      n_q[k] <= NW'(pa_q[k]) - NW'(pb_q[k]);
      w_q[k] <= NW'(wa_q[k]) - NW'(wb_q[k]);
    end
    degen_q <= &nzero;
  end

  assign n_o         = n_q;
  assign w_o         = w_q;
  assign ctl_o.valid = vld_q[2];
  assign ctl_o.degen = degen_q;

endmodule

[src/tlfg_wmul.sv]
module tlfg_wmul
  import tlfg_pkg::*;
(
  input  logic clk_i,
  input  nw_t  a_i,
  input  nw_t  b_i,
  output mw_t  p_o
);

  logic signed [HIW-1:0]   a_hi, b_hi;
  logic        [LO-1:0]    a_lo, b_lo;
  logic signed [2*HIW-1:0] hh_q;
  logic signed [HIW+LO:0]  hl_q, lh_q;
  logic        [2*LO-1:0]  ll_q;
  mw_t                     p_q;

  assign a_hi = a_i[NW-1:LO];
  assign b_hi = b_i[NW-1:LO];
  assign a_lo = a_i[LO-1:0];
  assign b_lo = b_i[LO-1:0];

  // Partial products on slices
  always_ff @(posedge clk_i) begin
    hh_q <= a_hi * b_hi;
    hl_q <= a_hi * $signed({1'b0, b_lo});
    lh_q <= $signed({1'b0, a_lo}) * b_hi;
    ll_q <= a_lo * b_lo;
  end

  // Recombine
  always_ff @(posedge clk_i) begin
    p_q <= (MW'(hh_q) << (2*LO)) + (MW'(hl_q) << LO) + (MW'(lh_q) << LO) + MW'(ll_q);
  end

  assign p_o = p_q;

endmodule

[src/tlfg_div.sv]
module tlfg_div
  import tlfg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cw_t  c_i [3],
  input  sw_t  s_i,
  input  ctl_t ctl_i,
  output xw_t  q_o [3],
  output ctl_t ctl_o
);

  logic [RW-1:0] rem_q [3][QW+1];
  logic [QW-1:0] qt_q  [3][QW+1];
  logic          neg_q [3][QW+1];
  logic          big_q [3][QW+1];
  logic [SW:0]   den_q [QW+1];
  ctl_t          ctl_q [QW+1];
  xw_t           res_q [3];
  ctl_t          out_q;

  // Control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= QW; j++) ctl_q[j] <= '0;
      out_q <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int j = 0; j < QW; j++) ctl_q[j+1] <= ctl_q[j];
      out_q <= ctl_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0] <= {s_i, 1'b0};
    for (int j = 0; j < QW; j++) den_q[j+1] <= den_q[j];
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [CW-1:0] absc;
    logic [RW-1:0] num;

    // Rounding offset: (|c| * 2^(F+1) + s) / 2s
    assign absc = c_i[l][CW-1] ? CW'(-c_i[l]) : CW'(c_i[l]);
    assign num  = (RW'(absc) << (FRAC_BITS + 1)) + RW'(s_i);

    always_ff @(posedge clk_i) begin
      rem_q[l][0] <= num;
      qt_q[l][0]  <= '0;
      neg_q[l][0] <= c_i[l][CW-1];
      big_q[l][0] <= num >= (RW'({s_i, 1'b0}) << QW);
    end

    // One quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_step
      logic [RW-1:0] trial;
      logic          ge;
      assign trial = RW'(den_q[j]) << (QW - 1 - j);
      assign ge    = rem_q[l][j] >= trial;
      always_ff @(posedge clk_i) begin
        rem_q[l][j+1] <= ge ? rem_q[l][j] - trial : rem_q[l][j];
        qt_q[l][j+1]  <= qt_q[l][j] | (ge ? (QW'(1) << (QW - 1 - j)) : '0);
        neg_q[l][j+1] <= neg_q[l][j];
        big_q[l][j+1] <= big_q[l][j];
      end
    end

    // Sign, saturation, degenerate zero
    always_ff @(posedge clk_i) begin
      if (ctl_q[QW].degen) begin
        res_q[l] <= '0;
      end else if (!neg_q[l][QW]) begin
        if (big_q[l][QW] || qt_q[l][QW][QW-1]) res_q[l] <= {1'b0, {(XW-1){1'b1}}};
        else res_q[l] <= xw_t'(qt_q[l][QW]);
      end else begin
        if (big_q[l][QW] || qt_q[l][QW] > {1'b1, {(QW-1){1'b0}}}) begin
          res_q[l] <= {1'b1, {(XW-1){1'b0}}};
        end else begin
          res_q[l] <= xw_t'(-qt_q[l][QW]);
        end
      end
    end
  end

  assign q_o   = res_q;
  assign ctl_o = out_q;

endmodule

[src/triangle_linear_field_gradient.sv]
// Gradient of a linear field over one triangle in 3D. A word enters on any
// cycle start is high; busy never rises, so a triangle can enter every clock.
// Each result is on the outputs for one cycle with done_o high, and cannot
// be held off: the sink must take it then. The pipeline is made of three
// difference/product stages, a two-stage sliced wide multiplier, one
// cross-product/norm stage and the 34-stage bit-per-stage divider (load,
// 32 quotient bits, sign and saturation).
// Degenerate triangles give a zero gradient with degenerate_o set.
module triangle_linear_field_gradient
  import tlfg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  xw_t  first_x_i,
  input  xw_t  first_y_i,
  input  xw_t  first_z_i,
  input  xw_t  second_x_i,
  input  xw_t  second_y_i,
  input  xw_t  second_z_i,
  input  xw_t  third_x_i,
  input  xw_t  third_y_i,
  input  xw_t  third_z_i,
  input  xw_t  first_value_i,
  input  xw_t  second_value_i,
  input  xw_t  third_value_i,
  output logic done_o,
  output xw_t  grad_x_o,
  output xw_t  grad_y_o,
  output xw_t  grad_z_o,
  output logic degenerate_o
);

  xw_t  p1 [3], p2 [3], p3 [3];
  nw_t  n [3], w [3];
  ctl_t fr_ctl, div_ctl;
  ctl_t mul_ctl_q [2];
  ctl_t cs_ctl_q;
  mw_t  pa [3], pb [3], sq [3];
  cw_t  c_q [3];
  sw_t  s_q;
  xw_t  grad [3];

  assign busy = 1'b0;

  assign p1 = '{first_x_i, first_y_i, first_z_i};
  assign p2 = '{second_x_i, second_y_i, second_z_i};
  assign p3 = '{third_x_i, third_y_i, third_z_i};

  tlfg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start && !busy),
    .p1_i   (p1),
    .p2_i   (p2),
    .p3_i   (p3),
    .v1_i   (first_value_i),
    .v2_i   (second_value_i),
    .v3_i   (third_value_i),
    .n_o    (n),
    .w_o    (w),
    .ctl_o  (fr_ctl)
  );

  // Wide products for n x w and |n|^2
  for (genvar k = 0; k < 3; k++) begin : g_mul
    tlfg_wmul u_pa (.clk_i(clk_i), .a_i(n[(k+1)%3]), .b_i(w[(k+2)%3]), .p_o(pa[k]));
    tlfg_wmul u_pb (.clk_i(clk_i), .a_i(n[(k+2)%3]), .b_i(w[(k+1)%3]), .p_o(pb[k]));
    tlfg_wmul u_sq (.clk_i(clk_i), .a_i(n[k]),       .b_i(n[k]),       .p_o(sq[k]));
  end

  // Control follows the multiplier stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ctl_q[0] <= '0;
      mul_ctl_q[1] <= '0;
      cs_ctl_q     <= '0;
    end else begin
      mul_ctl_q[0] <= fr_ctl;
      mul_ctl_q[1] <= mul_ctl_q[0];
      cs_ctl_q     <= mul_ctl_q[1];
    end
  end

  // Cross product components and squared norm
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) c_q[k] <= CW'(pa[k]) - CW'(pb[k]);
    s_q <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
  end

  tlfg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .c_i   (c_q),
    .s_i   (s_q),
    .ctl_i (cs_ctl_q),
    .q_o   (grad),
    .ctl_o (div_ctl)
  );

  assign grad_x_o     = grad[0];
  assign grad_y_o     = grad[1];
  assign grad_z_o     = grad[2];
  assign done_o       = div_ctl.valid;
  assign degenerate_o = div_ctl.degen;

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without matching input word");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (grad_x_o == '0 && grad_y_o == '0 && grad_z_o == '0))
    else $error("degenerate result with nonzero gradient");
  a_degen_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cs_ctl_q.valid && !cs_ctl_q.degen) |-> (s_q != '0))
    else $error("zero norm on a triangle with area");
`endif

endmodule

[bench/tb_triangle_linear_field_gradient.sv]
`timescale 1ns / 1ps

module tb_triangle_linear_field_gradient;
  import tlfg_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 60;

  // One triangle with its corner values
  typedef struct {
    xw_t x1, y1, z1, x2, y2, z2, x3, y3, z3;
    xw_t v1, v2, v3;
  } tri_word_t;

  // One gradient result
  typedef struct {
    xw_t gx, gy, gz;
    logic degen;
  } grad_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  xw_t first_x_i = '0, first_y_i = '0, first_z_i = '0;
  xw_t second_x_i = '0, second_y_i = '0, second_z_i = '0;
  xw_t third_x_i = '0, third_y_i = '0, third_z_i = '0;
  xw_t first_value_i = '0, second_value_i = '0, third_value_i = '0;
  logic done_o;
  xw_t grad_x_o, grad_y_o, grad_z_o;
  logic degenerate_o;

  tri_word_t pending_tris[$];
  grad_word_t expected_grads[$];
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit sending = 1'b0;
  bit hold_for_drain = 1'b0;
  bit stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  triangle_linear_field_gradient dut (.*);

  // Rounded, saturated c * 2^FRAC_BITS / s, ties away from zero
  function automatic xw_t scaled_div(logic signed [255:0] c, logic signed [255:0] s);
    logic signed [255:0] mag, q;
    mag = (c < 0) ? -c : c;
    q = ((mag <<< (FRAC_BITS + 1)) + s) / (s <<< 1);
    if (c >= 0) return (q > 256'sh7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    if (q > 256'sh80000000) return 32'h80000000;
    return -q[31:0];
  endfunction

  // Gradient as (n x w) / |n|^2 with exact wide integers
  function automatic grad_word_t field_gradient(tri_word_t t);
    logic signed [255:0] d2[3], d3[3], n[3], w[3], c[3], s, g2, g3;
    grad_word_t r;
    d2[0] = 256'(signed'(t.x2)) - 256'(signed'(t.x1));
    d2[1] = 256'(signed'(t.y2)) - 256'(signed'(t.y1));
    d2[2] = 256'(signed'(t.z2)) - 256'(signed'(t.z1));
    d3[0] = 256'(signed'(t.x3)) - 256'(signed'(t.x1));
    d3[1] = 256'(signed'(t.y3)) - 256'(signed'(t.y1));
    d3[2] = 256'(signed'(t.z3)) - 256'(signed'(t.z1));
    g2 = 256'(signed'(t.v2)) - 256'(signed'(t.v1));
    g3 = 256'(signed'(t.v3)) - 256'(signed'(t.v1));
    n[0] = d2[1] * d3[2] - d2[2] * d3[1];
    n[1] = d2[2] * d3[0] - d2[0] * d3[2];
    n[2] = d2[0] * d3[1] - d2[1] * d3[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.gx = '0; r.gy = '0; r.gz = '0; r.degen = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) w[k] = g3 * d2[k] - g2 * d3[k];
    c[0] = n[1] * w[2] - n[2] * w[1];
    c[1] = n[2] * w[0] - n[0] * w[2];
    c[2] = n[0] * w[1] - n[1] * w[0];
    s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    r.gx = scaled_div(c[0], s);
    r.gy = scaled_div(c[1], s);
    r.gz = scaled_div(c[2], s);
    r.degen = 1'b0;
    return r;
  endfunction

  // Coordinates: mostly small, sometimes extreme or fully random
  function automatic xw_t rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      4: return $signed($urandom_range(0, 2047)) - 1024;
      default: return ($signed($urandom_range(0, 65535)) - 32768) <<< 8;
    endcase
  endfunction

  function automatic tri_word_t rand_tri();
    tri_word_t t;
    t.x1 = rand_coord(); t.y1 = rand_coord(); t.z1 = rand_coord();
    t.x2 = rand_coord(); t.y2 = rand_coord(); t.z2 = rand_coord();
    t.x3 = rand_coord(); t.y3 = rand_coord(); t.z3 = rand_coord();
    t.v1 = rand_coord(); t.v2 = rand_coord(); t.v3 = rand_coord();
    case ($urandom_range(0, 9))
      0: begin t.x2 = t.x1; t.y2 = t.y1; t.z2 = t.z1; end
      1: begin
        // collinear: third on the line through first and second
        t.x1 = $signed($urandom_range(0, 4095)) - 2048;
        t.y1 = $signed($urandom_range(0, 4095)) - 2048;
        t.z1 = $signed($urandom_range(0, 4095)) - 2048;
        t.x2 = t.x1 + 7; t.y2 = t.y1 - 3; t.z2 = t.z1 + 5;
        t.x3 = t.x1 - 14; t.y3 = t.y1 + 6; t.z3 = t.z1 - 10;
      end
      2: begin t.x3 = t.x1; t.y3 = t.y1; t.z3 = t.z1; end
      default: ;
    endcase
    return t;
  endfunction

  function automatic tri_word_t make_tri(xw_t a, b, c, d, e, f, g, h, i, j, k, l);
    tri_word_t t;
    t.x1 = a; t.y1 = b; t.z1 = c; t.x2 = d; t.y2 = e; t.z2 = f;
    t.x3 = g; t.y3 = h; t.z3 = i; t.v1 = j; t.v2 = k; t.v3 = l;
    return t;
  endfunction

  // Append a triangle to the stimulus queue
  function void add_tri(input tri_word_t t);
    pending_tris = {pending_tris, t};
  endfunction

  // Driver: one word per handshake, random gap after each
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sending && !busy) begin
        sending = 1'b0;
      end
      if (!sending) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_tris.size() > 0 && !(hold_for_drain && expected_grads.size() > 0))
        begin
          tri_word_t t;
          t = pending_tris.pop_front();
          hold_for_drain = 1'b0;
          first_x_i <= t.x1; first_y_i <= t.y1; first_z_i <= t.z1;
          second_x_i <= t.x2; second_y_i <= t.y2; second_z_i <= t.z2;
          third_x_i <= t.x3; third_y_i <= t.y3; third_z_i <= t.z3;
          first_value_i <= t.v1; second_value_i <= t.v2; third_value_i <= t.v3;
          expected_grads = {expected_grads, field_gradient(t)};
          start <= 1'b1;
          sending = 1'b1;
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
          if ($urandom_range(0, 99) < 30) gap_left = 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles <= (done_o || (start && !busy)) ? 0 : idle_cycles + 1;
      if (done_o) begin
        if (expected_grads.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h degenerate=%b", $time,
                   grad_x_o, grad_y_o, grad_z_o, degenerate_o);
          errors++;
        end else begin
          grad_word_t e;
          e = expected_grads.pop_front();
          if (grad_x_o !== e.gx) begin
            $display("%0t: grad_x expected %h actual %h", $time, e.gx, grad_x_o);
            errors++;
          end
          if (grad_y_o !== e.gy) begin
            $display("%0t: grad_y expected %h actual %h", $time, e.gy, grad_y_o);
            errors++;
          end
          if (grad_z_o !== e.gz) begin
            $display("%0t: grad_z expected %h actual %h", $time, e.gz, grad_z_o);
            errors++;
          end
          if (degenerate_o !== e.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, e.degen,
                     degenerate_o);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    xw_t mx, mn;
    mx = 32'h7FFFFFFF;
    mn = 32'h80000000;
    // Directed words
    add_tri(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0,
                     0, 32'h10000, 32'h20000));
    add_tri(make_tri(0, 0, 0, 0, 0, 0, 5, 6, 7, 1, 2, 3));
    add_tri(make_tri(1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 5, 6));
    add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, mx, mn, mx));
    add_tri(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, mn, mx, mx));
    add_tri(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx, mx, mn, mn));
    add_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, mn, mx, mx));
    add_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, mx, mn, mn));
    add_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 3, 0, 0, 1, 2));
    add_tri(make_tri(0, 0, 0, 0, 0, 2, 0, 2, 0, 0, 1, 1));
    add_tri(make_tri(mn, 0, mx, mx, mn, 0, 0, mx, mn, 1, -1, 0));
    add_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    add_tri(make_tri(0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000,
                     32'h8000, -32'h8000, 32'h30000));
    for (int i = 0; i < 1350; i++) add_tri(rand_tri());
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Let part of the stream go, then pause until the pipeline drains
    wait (pending_tris.size() < 700);
    hold_for_drain = 1'b1;
    wait (pending_tris.size() == 0 && !sending);
    wait (expected_grads.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_grads.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/tlfg_pkg.sv
src/tlfg_front.sv
src/tlfg_wmul.sv
src/tlfg_div.sv
src/triangle_linear_field_gradient.sv
bench/tb_triangle_linear_field_gradient.sv
